>>> design/color_gradient_orientation_unit_assert.svh
// Assertion macros shared by the color gradient orientation unit
`ifndef COLOR_GRADIENT_ORIENTATION_UNIT_ASSERT_SVH
`define COLOR_GRADIENT_ORIENTATION_UNIT_ASSERT_SVH

// same-cycle implication
`define CGO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cgo_pkg.sv
// Types and constants of the color gradient orientation unit
`timescale 1ns / 1ps

package cgo_pkg;

  localparam int NUM_CH       = 3;
  localparam int SAMPLE_W     = 8;
  localparam int DIFF_W       = 9;
  localparam int MAG_W        = 9;
  localparam int ANGLE_W      = 16;
  localparam int CH_W         = 2;
  localparam int IN_DATA_W    = 96;
  localparam int OUT_DATA_W   = 32;
  localparam int CORDIC_STEPS = 19;
  localparam int SCALE_SHIFT  = 24;
  localparam int XY_W         = 36;
  localparam int Z_W          = 32;
  localparam int ZC_W         = 30;
  localparam int OUT_SHIFT    = 15;

  localparam logic signed [Z_W-1:0] HALF_PI_UNITS = 32'sd536870912;
  localparam logic [ANGLE_W-1:0]    ANGLE_PI      = 16'd32768;

  localparam logic signed [Z_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
    32'sd268435456, 32'sd158466703, 32'sd83729454, 32'sd42502378, 32'sd21333667,
    32'sd10677233,  32'sd5339919,   32'sd2670123,  32'sd1335082,  32'sd667543,
    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,    32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304
  };

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [CH_W-1:0]  ch;
    logic             zero;
    logic             hneg;
    logic             mirror;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic [ANGLE_W-1:0] angle;
    logic [CH_W-1:0]    ch;
  } res_t;

endpackage

>>> design/cgo_grad.sv
// Gradient, channel selection and quadrant fold stages
`timescale 1ns / 1ps

module cgo_grad import cgo_pkg::*; #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic [CH_W-1:0]      channel_count,
  output logic                 out_valid,
  output side_t                out_side,
  output vec_t                 out_vec
);

  logic signed [DIFF_W-1:0] dx_c [NUM_CH];
  logic signed [DIFF_W-1:0] dy_c [NUM_CH];
  logic [MAG_W-1:0]         mag_c [NUM_CH];
  logic [CH_W-1:0]          cnt;
  logic [CH_W-1:0]          lim;

  logic [MAG_W-1:0]         best_mag;
  logic signed [DIFF_W-1:0] best_dx;
  logic signed [DIFF_W-1:0] best_dy;
  logic [CH_W-1:0]          best_ch;

  logic                     a_valid_r;
  logic [MAG_W-1:0]         a_mag_r;
  logic signed [DIFF_W-1:0] a_dx_r;
  logic signed [DIFF_W-1:0] a_dy_r;
  logic [CH_W-1:0]          a_ch_r;

  logic signed [DIFF_W-1:0] fdx;
  logic signed [DIFF_W-1:0] fdy;
  logic signed [DIFF_W-1:0] adx;
  side_t                    side_nxt;
  vec_t                     vec_nxt;

  logic                     b_valid_r;
  side_t                    b_side_r;
  vec_t                     b_vec_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic signed [DIFF_W-1:0] ax;
      logic signed [DIFF_W-1:0] ay;
      dy_c[c] = $signed({1'b0, in_data[c*32+8 +: SAMPLE_W]})
              - $signed({1'b0, in_data[c*32 +: SAMPLE_W]});
      dx_c[c] = $signed({1'b0, in_data[c*32+24 +: SAMPLE_W]})
              - $signed({1'b0, in_data[c*32+16 +: SAMPLE_W]});
      ax = dx_c[c][DIFF_W-1] ? -dx_c[c] : dx_c[c];
      ay = dy_c[c][DIFF_W-1] ? -dy_c[c] : dy_c[c];
      mag_c[c] = {1'b0, ax[SAMPLE_W-1:0]} + {1'b0, ay[SAMPLE_W-1:0]};
    end
  end

  // zero count behaves as one, counts above the parameter saturate
  assign cnt = (channel_count == '0) ? CH_W'(1) : channel_count;
  assign lim = (cnt > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : cnt;

  // ties keep the lower channel
  always_comb begin
    best_mag = mag_c[0];
    best_dx  = dx_c[0];
    best_dy  = dy_c[0];
    best_ch  = '0;
    for (int c = 1; c < NUM_CH; c++) begin
      if ((CH_W'(c) < lim) && (mag_c[c] > best_mag)) begin
        best_mag = mag_c[c];
        best_dx  = dx_c[c];
        best_dy  = dy_c[c];
        best_ch  = CH_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r <= best_mag;
      a_dx_r  <= best_dx;
      a_dy_r  <= best_dy;
      a_ch_r  <= best_ch;
    end
  end

  // negative dy turns the vector by pi; a negative turned dx mirrors about pi/2
  always_comb begin
    fdx = a_dy_r[DIFF_W-1] ? -a_dx_r : a_dx_r;
    fdy = a_dy_r[DIFF_W-1] ? -a_dy_r : a_dy_r;
    adx = fdx[DIFF_W-1] ? -fdx : fdx;
    side_nxt.mag    = a_mag_r;
    side_nxt.ch     = a_ch_r;
    side_nxt.zero   = (a_dx_r == '0) && (a_dy_r == '0);
    side_nxt.hneg   = (fdy == '0) && fdx[DIFF_W-1];
    side_nxt.mirror = fdx[DIFF_W-1];
    vec_nxt.x = $signed({{(XY_W-SAMPLE_W-SCALE_SHIFT){1'b0}}, adx[SAMPLE_W-1:0],
                         {SCALE_SHIFT{1'b0}}});
    vec_nxt.y = $signed({{(XY_W-SAMPLE_W-SCALE_SHIFT){1'b0}}, fdy[SAMPLE_W-1:0],
                         {SCALE_SHIFT{1'b0}}});
    vec_nxt.z = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= side_nxt;
      b_vec_r  <= vec_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_side  = b_side_r;
  assign out_vec   = b_vec_r;

endmodule

>>> design/cgo_cordic_stage.sv
// One registered CORDIC vectoring iteration
`timescale 1ns / 1ps

module cgo_cordic_stage import cgo_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  input  vec_t  in_vec,
  output logic  out_valid,
  output side_t out_side,
  output vec_t  out_vec
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  vec_t                   vec_nxt;

  logic                   valid_r;
  side_t                  side_r;
  vec_t                   vec_r;

  assign x  = in_vec.x;
  assign y  = in_vec.y;
  assign xs = x >>> STEP;
  assign ys = y >>> STEP;

  always_comb begin
    if (!y[XY_W-1]) begin
      vec_nxt.x = x + ys;
      vec_nxt.y = y - xs;
      vec_nxt.z = in_vec.z + ATAN_UNITS[STEP];
    end else begin
      vec_nxt.x = x - ys;
      vec_nxt.y = y + xs;
      vec_nxt.z = in_vec.z - ATAN_UNITS[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      vec_r  <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_vec   = vec_r;

endmodule

>>> design/cgo_finish.sv
// Angle clamp, rounding and unfold stage
`timescale 1ns / 1ps

`include "color_gradient_orientation_unit_assert.svh"

module cgo_finish import cgo_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  input  vec_t  in_vec,
  output logic  out_valid,
  output res_t  out_res
);

  logic [ZC_W-1:0]    zc;
  logic [ZC_W-1:0]    zr;
  logic [ANGLE_W-1:0] base;
  res_t               res_nxt;

  logic               valid_r;
  res_t               res_r;

  always_comb begin
    if (in_vec.z[Z_W-1]) begin
      zc = '0;
    end else if (in_vec.z > HALF_PI_UNITS) begin
      zc = HALF_PI_UNITS[ZC_W-1:0];
    end else begin
      zc = in_vec.z[ZC_W-1:0];
    end
    zr   = zc + ZC_W'(1 << (OUT_SHIFT - 1));
    base = ANGLE_W'(zr[ZC_W-1:OUT_SHIFT]);
    res_nxt.mag = in_side.mag;
    res_nxt.ch  = in_side.ch;
    if (in_side.zero) begin
      res_nxt.angle = '0;
    end else if (in_side.hneg) begin
      res_nxt.angle = ANGLE_PI;
    end else if (in_side.mirror) begin
      res_nxt.angle = ANGLE_PI - base;
    end else begin
      res_nxt.angle = base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  `CGO_ASSERT_NOW(a_angle_range, clk, rst_n, valid_r, res_r.angle <= ANGLE_PI, "angle above pi")

endmodule

>>> design/cgo_skid.sv
// Output register with skid slot; its fill state stalls the pipeline
`timescale 1ns / 1ps

`include "color_gradient_orientation_unit_assert.svh"

module cgo_skid import cgo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_res,
  output logic pipe_en,
  output logic out_valid,
  output res_t out_res,
  input  logic out_ready
);

  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;
  logic skid_valid_r;
  logic skid_valid_nxt;
  res_t skid_res_r;
  logic out_free;
  logic incoming;
  logic load_out;
  logic load_skid;

  assign pipe_en  = !skid_valid_r;
  assign out_free = !out_valid_r || out_ready;
  assign incoming = in_valid && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_r) begin
      if (out_free) begin
        load_out       = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (incoming) begin
      if (out_free) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_valid_r ? skid_res_r : in_res;
    end
    if (load_skid) begin
      skid_res_r <= in_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `CGO_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid word without output word")
  `CGO_ASSERT_NEXT(a_skid_needs_stall, clk, rst_n, !out_valid_r, !skid_valid_r, "skid filled while output free")
  `CGO_ASSERT_NEXT(a_skid_catches, clk, rst_n, in_valid && !skid_valid_r && out_valid_r && !out_ready, skid_valid_r, "stalled word dropped")

endmodule

>>> design/color_gradient_orientation_unit.sv
// An accepted input word passes the gradient, CORDIC and finish registers, then the output register.
// Throughput: one pixel per cycle while in_tready is high; 19 CORDIC stages, one iteration each.
// A two-entry output buffer holds results under backpressure; in_tready
// drops only while its second slot is full.
// Reset (rst_n low, synchronous) empties the pipeline and sets channel_count to 3.
`timescale 1ns / 1ps

module color_gradient_orientation_unit import cgo_pkg::*; #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CH_W-1:0]       cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // c0_up, c0_down, c0_left, c0_right, c1_up .. c1_right, c2_up .. c2_right
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // grad_magnitude [8:0], grad_angle [24:9], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // winning_channel [1:0]
  output logic [CH_W-1:0]       out_tuser
);

  logic [CH_W-1:0] channel_count_q_r;
  logic            pipe_en;

  logic            vld  [CORDIC_STEPS+1];
  side_t           side [CORDIC_STEPS+1];
  vec_t            vec  [CORDIC_STEPS+1];

  logic            fin_valid;
  res_t            fin_res;
  res_t            out_res;

  // channel_count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_q_r <= CH_W'(3);
    end else if (cfg_wr_en) begin
      channel_count_q_r <= cfg_wr_data;
    end
  end

  assign in_tready = pipe_en;

  cgo_grad #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_grad (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pipe_en),
    .in_valid     (in_tvalid),
    .in_data      (in_tdata),
    .channel_count(channel_count_q_r),
    .out_valid    (vld[0]),
    .out_side     (side[0]),
    .out_vec      (vec[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cgo_cordic_stage #(
      .STEP(i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_valid (vld[i]),
      .in_side  (side[i]),
      .in_vec   (vec[i]),
      .out_valid(vld[i+1]),
      .out_side (side[i+1]),
      .out_vec  (vec[i+1])
    );
  end

  cgo_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (vld[CORDIC_STEPS]),
    .in_side  (side[CORDIC_STEPS]),
    .in_vec   (vec[CORDIC_STEPS]),
    .out_valid(fin_valid),
    .out_res  (fin_res)
  );

  cgo_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fin_valid),
    .in_res   (fin_res),
    .pipe_en  (pipe_en),
    .out_valid(out_tvalid),
    .out_res  (out_res),
    .out_ready(out_tready)
  );

  assign out_tdata = {{(OUT_DATA_W-MAG_W-ANGLE_W){1'b0}}, out_res.angle, out_res.mag};
  assign out_tuser = out_res.ch;

endmodule
